/* src/lin_master_frame_engine_macros.svh */
// Assertion macros shared by the frame engine checkers.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef LIN_MASTER_FRAME_ENGINE_MACROS_SVH
`define LIN_MASTER_FRAME_ENGINE_MACROS_SVH

// Same-cycle implication
`define LMFE_ASSERT_HOLDS(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define LMFE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/lmfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lmfe_pkg;

    // Table sizing
    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int ID_SPACE    = 64;
    localparam int ID_W        = $clog2(ID_SPACE);

    // Protocol constants
    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [7:0] BREAK_BYTE   = 8'h00;
    localparam logic [5:0] ENH_ID_LIMIT = 6'h3C;
    localparam logic [3:0] MAX_LEN      = 4'd8;

    // Input item codes
    typedef enum logic [2:0] {
        MODE_REGISTER = 3'd0,
        MODE_BEGIN    = 3'd1,
        MODE_TX_START = 3'd2,
        MODE_TX_DATA  = 3'd3,
        MODE_RX_START = 3'd4,
        MODE_RX_DATA  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        KIND_BREAK = 3'd0,
        KIND_SYNC  = 3'd1,
        KIND_PID   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_CSUM  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_WRONG_STATE  = 3'd1,
        ST_TABLE_FULL   = 3'd2,
        ST_BAD_ID       = 3'd3,
        ST_BAD_LENGTH   = 3'd4,
        ST_UNKNOWN_ID   = 3'd5,
        ST_CSUM_ERROR   = 3'd6,
        ST_OUT_OF_SEQ   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TX   = 2'd1,
        PH_RX   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MAP,
        S_TAB,
        S_HDR,
        S_CSUM
    } state_t;

    // One frame table entry
    typedef struct packed {
        logic [7:0] pid;
        logic [3:0] len;
        logic       enh;
    } entry_t;

    // Protected id: parity bits in 6 and 7
    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // 8-bit add with end-around carry
    function automatic logic [7:0] wrap_add(input logic [7:0] s, input logic [7:0] d);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, d};
        return t[7:0] + {7'd0, t[8]};
    endfunction

endpackage

`default_nettype wire

/* src/lmfe_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lmfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] frame_id;
    logic [3:0] frame_length;
    logic       use_enhanced;
    logic [7:0] data_byte;

    modport source (
        output valid, mode, frame_id, frame_length, use_enhanced, data_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, frame_id, frame_length, use_enhanced, data_byte,
        output ready
    );
endinterface

`default_nettype wire

/* src/lmfe_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lmfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic [2:0] byte_kind;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;

    modport source (
        output valid, line_byte, byte_kind, byte_valid, status, last,
        input  ready
    );
    modport sink (
        input  valid, line_byte, byte_kind, byte_valid, status, last,
        output ready
    );
endinterface

`default_nettype wire

/* src/lmfe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/lin_master_frame_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Payload
// item_in     in   mode, frame_id, frame_length, use_enhanced, data_byte
// result_out  out  line_byte, byte_kind, byte_valid, status, last
//
// One item at a time: each is accepted in S_IDLE and then decoded in S_DECODE.
// A header start then reads the id map (S_MAP), then the entry table (S_TAB),
// both synchronous RAMs with a registered read, then emits four results in S_HDR.
// Results pass through a single output register; any result stalls while it
// is held. Reset clears map valid bits, count, freeze and frame state; no
// clearing pass is needed.

module lin_master_frame_engine (
    input  logic        clk,
    input  logic        rst_n,
    lmfe_in_if.sink     item_in,
    lmfe_out_if.source  result_out
);
    import lmfe_pkg::*;

    // Control state
    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  frozen_reg, frozen_next;
    phase_t                phase_reg, phase_next;
    logic [3:0]            flen_reg, flen_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            pid_reg, pid_next;
    logic [1:0]            hdr_idx_reg, hdr_idx_next;
    logic [ID_SPACE-1:0]   map_valid_reg, map_valid_next;

    // Latched item
    logic [2:0]            mode_reg;
    logic [7:0]            id_reg;
    logic [3:0]            len_reg;
    logic                  enh_reg;
    logic [7:0]            data_reg;

    // Output register
    logic                  ovalid_reg;
    logic [7:0]            obyte_reg;
    kind_t                 okind_reg;
    logic                  obv_reg;
    status_t               ostat_reg;
    logic                  olast_reg;

    // Result being produced this cycle
    logic                  emit;
    logic [7:0]            e_byte;
    kind_t                 e_kind;
    logic                  e_bv;
    status_t               e_stat;
    logic                  e_last;
    logic                  out_free;
    logic                  accept;
    logic                  tx_final;

    // Memories
    logic                  map_we;
    logic [ENTRY_AW-1:0]   map_wdata;
    logic [ENTRY_AW-1:0]   map_rdata;
    logic                  tab_we;
    entry_t                tab_wdata;
    entry_t                tab_rdata;

    lmfe_ram #(
        .WIDTH (ENTRY_AW),
        .DEPTH (ID_SPACE)
    ) u_id_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (id_reg[ID_W-1:0]),
        .wdata (map_wdata),
        .raddr (id_reg[ID_W-1:0]),
        .rdata (map_rdata)
    );

    lmfe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (count_reg[ENTRY_AW-1:0]),
        .wdata (tab_wdata),
        .raddr (map_rdata),
        .rdata (tab_rdata)
    );

    assign accept         = item_in.valid && item_in.ready;
    assign item_in.ready  = (state_reg == S_IDLE);
    assign out_free       = !ovalid_reg || result_out.ready;
    assign tx_final       = ({1'b0, cnt_reg} + 5'd1) >= {1'b0, flen_reg};

    assign map_wdata = count_reg[ENTRY_AW-1:0];
    assign tab_wdata = '{pid: make_pid(id_reg[ID_W-1:0]), len: len_reg, enh: enh_reg};

    // Next state and results
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        frozen_next    = frozen_reg;
        phase_next     = phase_reg;
        flen_next      = flen_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        pid_next       = pid_reg;
        hdr_idx_next   = hdr_idx_reg;
        map_valid_next = map_valid_reg;
        emit           = 1'b0;
        e_byte         = 8'd0;
        e_kind         = KIND_BREAK;
        e_bv           = 1'b0;
        e_stat         = ST_OK;
        e_last         = 1'b1;
        map_we         = 1'b0;
        tab_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (mode_reg)
                    MODE_REGISTER:
                    begin
                        emit = 1'b1;
                        if (frozen_reg)
                            e_stat = ST_WRONG_STATE;
                        else if (count_reg == COUNT_W'(MAX_ENTRIES))
                            e_stat = ST_TABLE_FULL;
                        else if (id_reg[7:ID_W] != '0)
                            e_stat = ST_BAD_ID;
                        else if (len_reg == 4'd0 || len_reg > MAX_LEN)
                            e_stat = ST_BAD_LENGTH;
                        if (out_free)
                        begin
                            state_next = S_IDLE;
                            if (e_stat == ST_OK)
                            begin
                                map_we = 1'b1;
                                tab_we = 1'b1;
                                map_valid_next[id_reg[ID_W-1:0]] = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                    end

                    MODE_BEGIN:
                    begin
                        emit = 1'b1;
                        if (out_free)
                        begin
                            frozen_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end

                    MODE_TX_START, MODE_RX_START:
                    begin
                        if (!frozen_reg || id_reg[7:ID_W] != '0
                            || !map_valid_reg[id_reg[ID_W-1:0]])
                        begin
                            emit = 1'b1;
                            if (!frozen_reg)
                                e_stat = ST_WRONG_STATE;
                            else if (id_reg[7:ID_W] != '0)
                                e_stat = ST_BAD_ID;
                            else
                                e_stat = ST_UNKNOWN_ID;
                            if (out_free)
                                state_next = S_IDLE;
                        end
                        else
                        begin
                            // map read issued this cycle
                            state_next = S_MAP;
                        end
                    end

                    MODE_TX_DATA:
                    begin
                        emit = 1'b1;
                        if (phase_reg != PH_TX)
                        begin
                            e_stat = ST_OUT_OF_SEQ;
                            if (out_free)
                                state_next = S_IDLE;
                        end
                        else
                        begin
                            e_byte = data_reg;
                            e_kind = KIND_DATA;
                            e_bv   = 1'b1;
                            e_last = !tx_final;
                            if (out_free)
                            begin
                                sum_next = wrap_add(sum_reg, data_reg);
                                cnt_next = cnt_reg + 4'd1;
                                if (tx_final)
                                begin
                                    phase_next = PH_IDLE;
                                    state_next = S_CSUM;
                                end
                                else
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                        end
                    end

                    MODE_RX_DATA:
                    begin
                        emit = 1'b1;
                        if (phase_reg != PH_RX)
                        begin
                            e_stat = ST_OUT_OF_SEQ;
                        end
                        else if (cnt_reg < flen_reg)
                        begin
                            if (out_free)
                            begin
                                sum_next = wrap_add(sum_reg, data_reg);
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            e_stat = (data_reg == ~sum_reg) ? ST_OK : ST_CSUM_ERROR;
                            if (out_free)
                                phase_next = PH_IDLE;
                        end
                        if (out_free)
                            state_next = S_IDLE;
                    end

                    default:
                    begin
                        emit   = 1'b1;
                        e_stat = ST_WRONG_STATE;
                        if (out_free)
                            state_next = S_IDLE;
                    end
                endcase
            end

            S_MAP:
            begin
                // map data addresses the entry table
                state_next = S_TAB;
            end

            S_TAB:
            begin
                pid_next     = tab_rdata.pid;
                flen_next    = tab_rdata.len;
                cnt_next     = 4'd0;
                sum_next     = (tab_rdata.enh && id_reg[ID_W-1:0] < ENH_ID_LIMIT)
                               ? tab_rdata.pid : 8'd0;
                phase_next   = (mode_reg == MODE_TX_START) ? PH_TX : PH_RX;
                hdr_idx_next = 2'd0;
                state_next   = S_HDR;
            end

            S_HDR:
            begin
                emit   = 1'b1;
                e_bv   = 1'b1;
                e_last = 1'b0;
                case (hdr_idx_reg)
                    2'd2:
                    begin
                        e_byte = SYNC_BYTE;
                        e_kind = KIND_SYNC;
                    end
                    2'd3:
                    begin
                        e_byte = pid_reg;
                        e_kind = KIND_PID;
                        e_last = 1'b1;
                    end
                    default:
                    begin
                        e_byte = BREAK_BYTE;
                        e_kind = KIND_BREAK;
                    end
                endcase
                if (out_free)
                begin
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    if (hdr_idx_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end

            S_CSUM:
            begin
                emit   = 1'b1;
                e_byte = ~sum_reg;
                e_kind = KIND_CSUM;
                e_bv   = 1'b1;
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            frozen_reg    <= 1'b0;
            phase_reg     <= PH_IDLE;
            flen_reg      <= 4'd0;
            cnt_reg       <= 4'd0;
            sum_reg       <= 8'd0;
            pid_reg       <= 8'd0;
            hdr_idx_reg   <= 2'd0;
            map_valid_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            frozen_reg    <= frozen_next;
            phase_reg     <= phase_next;
            flen_reg      <= flen_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            pid_reg       <= pid_next;
            hdr_idx_reg   <= hdr_idx_next;
            map_valid_reg <= map_valid_next;
            if (emit && out_free)
                ovalid_reg <= 1'b1;
            else if (result_out.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= item_in.mode;
            id_reg   <= item_in.frame_id;
            len_reg  <= item_in.frame_length;
            enh_reg  <= item_in.use_enhanced;
            data_reg <= item_in.data_byte;
        end
        if (emit && out_free)
        begin
            obyte_reg <= e_byte;
            okind_reg <= e_kind;
            obv_reg   <= e_bv;
            ostat_reg <= e_stat;
            olast_reg <= e_last;
        end
    end

    assign result_out.valid      = ovalid_reg;
    assign result_out.line_byte  = obyte_reg;
    assign result_out.byte_kind  = okind_reg;
    assign result_out.byte_valid = obv_reg;
    assign result_out.status     = ostat_reg;
    assign result_out.last       = olast_reg;

endmodule

`default_nettype wire

/* src/lmfe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "lin_master_frame_engine_macros.svh"

module lmfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line_byte,
    input logic [2:0] byte_kind,
    input logic       byte_valid,
    input logic [2:0] status,
    input logic       last
);
    import lmfe_pkg::*;

    // Held result keeps its payload
    `LMFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(line_byte) && $stable(status) && $stable(last), "result changed while stalled")

    // Items are taken one at a time
    `LMFE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")

    // Undriven bytes read as zero break kind
    `LMFE_ASSERT_HOLDS(a_idle_byte, out_valid && !byte_valid, line_byte == 8'd0 && byte_kind == KIND_BREAK, "non-driven result carries a byte")

    // A driven byte always reports ok
    `LMFE_ASSERT_HOLDS(a_drive_ok, out_valid && byte_valid, status == ST_OK, "driven byte with error status")

    // Sync byte is fixed and never closes an item
    `LMFE_ASSERT_HOLDS(a_sync, out_valid && byte_kind == KIND_SYNC, line_byte == SYNC_BYTE && byte_valid && !last, "bad sync result")

endmodule

bind lin_master_frame_engine lmfe_checker u_lmfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .line_byte  (result_out.line_byte),
    .byte_kind  (result_out.byte_kind),
    .byte_valid (result_out.byte_valid),
    .status     (result_out.status),
    .last       (result_out.last)
);

`default_nettype wire

/* verif/tb_lin_master_frame_engine.sv */
`timescale 1ns / 1ps

module tb_lin_master_frame_engine;
    import lmfe_pkg::*;

    // Spare mode codes, answered with wrong state
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    // Results that drive no byte carry zero in both fields
    localparam logic [7:0] NO_BYTE = 8'h00;
    localparam kind_t      NO_KIND = KIND_BREAK;
    localparam int RANDOM_ITEMS  = 360;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] frame_id;
        logic [3:0] frame_length;
        logic       use_enhanced;
        logic [7:0] data_byte;
        bit         hold;          // wait for every owed result before offering
    } lin_req_t;

    typedef struct {
        logic [7:0] line_byte;
        kind_t      kind;
        logic       byte_valid;
        status_t    status;
        logic       last;
    } line_result_t;

    logic clk;
    logic rst_n;

    lmfe_in_if  item_in ();
    lmfe_out_if result_out ();

    lin_master_frame_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out)
    );

    lin_req_t     lin_requests[$];
    line_result_t bus_results_due[$];
    int           mismatch_count;

    // Shadow of the frame engine
    logic [7:0] tbl_pid [MAX_ENTRIES];
    logic [3:0] tbl_len [MAX_ENTRIES];
    logic       tbl_enh [MAX_ENTRIES];
    bit         map_ok  [ID_SPACE];
    int         map_idx [ID_SPACE];
    int         n_entries;
    bit         is_frozen;
    phase_t     phase = PH_IDLE;
    int         cur_entry;
    logic [3:0] nbytes;
    logic [7:0] csum_acc;

    // What the stimulus side knows of the table, for well-formed frames
    bit         gen_ok  [ID_SPACE];
    logic [3:0] gen_len [ID_SPACE];
    logic       gen_enh [ID_SPACE];
    int         live_ids[$];

    // Driver and monitor state
    bit          fire;
    bit          offer;
    int          burst_left;
    int          gap_left;
    logic [15:0] stall_mask;
    int          mon_tick;
    line_result_t got;
    line_result_t exp;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Id with parity bits on top
    function automatic logic [7:0] protect_id(logic [5:0] id);
        logic p0;
        logic p1;
        p0 = ^{id[4], id[2], id[1], id[0]};
        p1 = ~^{id[5], id[4], id[3], id[1]};
        return {p1, p0, id};
    endfunction

    // 8-bit sum, carry folded back into bit 0
    function automatic logic [7:0] carry_fold_add(logic [7:0] acc, logic [7:0] d);
        logic [8:0] t;
        t = acc + d;
        return t[7:0] + t[8];
    endfunction

    function void owe(logic [7:0] b, kind_t k, logic bv, status_t st, logic lst);
        line_result_t e;
        e.line_byte  = b;
        e.kind       = k;
        e.byte_valid = bv;
        e.status     = st;
        e.last       = lst;
        bus_results_due.push_back(e);
    endfunction

    // Expected bus results of one accepted item
    function void forecast_lin_results(lin_req_t r);
        status_t st;
        int      e;
        st = ST_OK;
        case (r.mode)
            MODE_REGISTER:
            begin
                if (is_frozen)
                    st = ST_WRONG_STATE;
                else if (n_entries >= MAX_ENTRIES)
                    st = ST_TABLE_FULL;
                else if (r.frame_id >= ID_SPACE)
                    st = ST_BAD_ID;
                else if (r.frame_length == 0 || r.frame_length > MAX_LEN)
                    st = ST_BAD_LENGTH;
                else
                begin
                    tbl_pid[n_entries] = protect_id(r.frame_id[5:0]);
                    tbl_len[n_entries] = r.frame_length;
                    tbl_enh[n_entries] = r.use_enhanced;
                    map_ok[r.frame_id]  = 1'b1;
                    map_idx[r.frame_id] = n_entries;
                    n_entries++;
                end
                owe(NO_BYTE, NO_KIND, 1'b0, st, 1'b1);
            end
            MODE_BEGIN:
            begin
                is_frozen = 1'b1;
                owe(NO_BYTE, NO_KIND, 1'b0, ST_OK, 1'b1);
            end
            MODE_TX_START, MODE_RX_START:
            begin
                if (!is_frozen)
                    st = ST_WRONG_STATE;
                else if (r.frame_id >= ID_SPACE)
                    st = ST_BAD_ID;
                else if (!map_ok[r.frame_id])
                    st = ST_UNKNOWN_ID;
                if (st != ST_OK)
                    owe(NO_BYTE, NO_KIND, 1'b0, st, 1'b1);
                else
                begin
                    // any frame in flight is dropped
                    e = map_idx[r.frame_id];
                    cur_entry = e;
                    nbytes    = '0;
                    csum_acc  = (tbl_enh[e] && r.frame_id < ENH_ID_LIMIT) ? tbl_pid[e] : 8'h00;
                    phase     = (r.mode == MODE_TX_START) ? PH_TX : PH_RX;
                    owe(BREAK_BYTE, KIND_BREAK, 1'b1, ST_OK, 1'b0);
                    owe(BREAK_BYTE, KIND_BREAK, 1'b1, ST_OK, 1'b0);
                    owe(SYNC_BYTE, KIND_SYNC, 1'b1, ST_OK, 1'b0);
                    owe(tbl_pid[e], KIND_PID, 1'b1, ST_OK, 1'b1);
                end
            end
            MODE_TX_DATA:
            begin
                if (phase != PH_TX)
                    owe(NO_BYTE, NO_KIND, 1'b0, ST_OUT_OF_SEQ, 1'b1);
                else
                begin
                    csum_acc = carry_fold_add(csum_acc, r.data_byte);
                    nbytes++;
                    if (nbytes >= tbl_len[cur_entry])
                    begin
                        phase = PH_IDLE;
                        owe(r.data_byte, KIND_DATA, 1'b1, ST_OK, 1'b0);
                        owe(~csum_acc, KIND_CSUM, 1'b1, ST_OK, 1'b1);
                    end
                    else
                        owe(r.data_byte, KIND_DATA, 1'b1, ST_OK, 1'b1);
                end
            end
            MODE_RX_DATA:
            begin
                if (phase != PH_RX)
                    owe(NO_BYTE, NO_KIND, 1'b0, ST_OUT_OF_SEQ, 1'b1);
                else if (nbytes < tbl_len[cur_entry])
                begin
                    csum_acc = carry_fold_add(csum_acc, r.data_byte);
                    nbytes++;
                    owe(NO_BYTE, NO_KIND, 1'b0, ST_OK, 1'b1);
                end
                else
                begin
                    // checksum byte closes the frame
                    phase = PH_IDLE;
                    st = (r.data_byte == ~csum_acc) ? ST_OK : ST_CSUM_ERROR;
                    owe(NO_BYTE, NO_KIND, 1'b0, st, 1'b1);
                end
            end
            default:
                owe(NO_BYTE, NO_KIND, 1'b0, ST_WRONG_STATE, 1'b1);
        endcase
    endfunction

    function void queue_item(logic [2:0] mode, logic [7:0] id, logic [3:0] len,
                             logic enh, logic [7:0] data, bit hold);
        lin_req_t r;
        r.mode         = mode;
        r.frame_id     = id;
        r.frame_length = len;
        r.use_enhanced = enh;
        r.data_byte    = data;
        r.hold         = hold;
        lin_requests.push_back(r);
    endfunction

    // Registration that is known to succeed
    function void queue_register(logic [5:0] id, logic [3:0] len, logic enh);
        queue_item(MODE_REGISTER, {2'b00, id}, len, enh, $urandom, 1'b0);
        gen_ok[id]  = 1'b1;
        gen_len[id] = len;
        gen_enh[id] = enh;
        live_ids.push_back(id);
    endfunction

    // Driver: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_in.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            fire = item_in.valid && item_in.ready;
            if (fire)
                forecast_lin_results(lin_requests.pop_front());
            if (!item_in.valid || fire)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (lin_requests.size() > 0 &&
                         (!lin_requests[0].hold || bus_results_due.size() == 0))
                begin
                    offer = 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(1, 12);
                end
                item_in.valid <= offer;
                if (offer)
                begin
                    item_in.mode         <= lin_requests[0].mode;
                    item_in.frame_id     <= lin_requests[0].frame_id;
                    item_in.frame_length <= lin_requests[0].frame_length;
                    item_in.use_enhanced <= lin_requests[0].use_enhanced;
                    item_in.data_byte    <= lin_requests[0].data_byte;
                end
            end
        end
    end

    // Monitor: rotating ready pattern, compare against the oldest owed result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
            stall_mask = 16'hFFFF;
            mon_tick   = 0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                got.line_byte  = result_out.line_byte;
                got.kind       = kind_t'(result_out.byte_kind);
                got.byte_valid = result_out.byte_valid;
                got.status     = status_t'(result_out.status);
                got.last       = result_out.last;
                if (bus_results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing owed: byte %h kind %0d bv %b st %0d last %b",
                                 $time, got.line_byte, got.kind, got.byte_valid, got.status,
                                 got.last);
                end
                else
                begin
                    exp = bus_results_due.pop_front();
                    if (got.line_byte !== exp.line_byte || got.kind !== exp.kind ||
                        got.byte_valid !== exp.byte_valid || got.status !== exp.status ||
                        got.last !== exp.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: exp byte %h kind %0d bv %b st %0d last %b / got %h %0d %b %0d %b",
                                     $time, exp.line_byte, exp.kind, exp.byte_valid, exp.status,
                                     exp.last, got.line_byte, got.kind, got.byte_valid,
                                     got.status, got.last);
                    end
                end
            end
            // new stall pattern now and then; bit 0 kept so the sink never locks up
            mon_tick++;
            if (mon_tick % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = $urandom | 16'h0001;
                    2: stall_mask = ($urandom & $urandom & $urandom) | 16'h0001;
                    default: stall_mask = ~($urandom & $urandom) | 16'h0001;
                endcase
            end
            stall_mask = {stall_mask[0], stall_mask[15:1]};
            result_out.ready <= stall_mask[0];
        end
    end

    // Stimulus and end of run
    initial
    begin
        int         n_directed;
        int         pick;
        int         id;
        int         n;
        int         frame_no;
        bit         tx;
        logic [3:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] flip;

        rst_n = 1'b0;
        item_in.valid        = 1'b0;
        item_in.mode         = MODE_REGISTER;
        item_in.frame_id     = '0;
        item_in.frame_length = '0;
        item_in.use_enhanced = 1'b0;
        item_in.data_byte    = '0;
        result_out.ready     = 1'b0;
        frame_no = 0;

        // Before freeze: spare modes, early starts, stray bytes, bad registrations
        queue_item(MODE_SPARE_6, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_SPARE_7, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_TX_START, 8'd5, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_RX_START, 8'd5, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_TX_DATA, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_RX_DATA, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd64, 4'd4, 1'b1, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd255, 4'd4, 1'b0, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd10, 4'd0, 1'b1, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd10, 4'd9, 1'b0, $urandom, 1'b0);

        // Good registrations: id and length extremes, either side of the
        // enhanced id limit, and a re-registration of the same id
        queue_register(6'd0, 4'd1, 1'b1);
        queue_register(6'd63, 4'd8, 1'b1);
        queue_register(6'h3B, 4'd8, 1'b1);
        queue_register(6'h3C, 4'd2, 1'b1);
        queue_register(6'h2A, 4'd3, 1'b0);
        queue_register(6'h15, 4'd5, 1'b1);
        queue_register(6'h2A, 4'd8, 1'b1);
        while (live_ids.size() < MAX_ENTRIES)
            queue_register($urandom_range(0, 63), $urandom_range(1, 8), $urandom);

        // Full table wins over bad id and length; then freeze
        queue_item(MODE_REGISTER, 8'd200, 4'd0, 1'b1, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd1, 4'd4, 1'b0, $urandom, 1'b0);
        queue_item(MODE_BEGIN, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_item(MODE_REGISTER, 8'd200, 4'd0, 1'b1, $urandom, 1'b0);
        queue_item(MODE_BEGIN, $urandom, $urandom, $urandom, $urandom, 1'b0);
        n_directed = lin_requests.size();

        // Mostly whole frames, the rest noise and cut-short frames
        while (lin_requests.size() < n_directed + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            id   = live_ids[$urandom_range(0, live_ids.size() - 1)];
            len  = gen_len[id];
            if (pick < 72)
            begin
                tx = (pick < 36) || (pick >= 64 && pick % 2 == 1);
                queue_item(tx ? MODE_TX_START : MODE_RX_START, id, $urandom, $urandom,
                           $urandom, (frame_no % 30) == 0);
                frame_no++;
                sum = (gen_enh[id] && id < ENH_ID_LIMIT) ? protect_id(id) : 8'h00;
                n = (pick >= 64) ? $urandom_range(0, len - 1) : len;
                for (int k = 0; k < n; k++)
                begin
                    b = ($urandom_range(0, 3) == 0) ? 8'hFF : $urandom;
                    sum = carry_fold_add(sum, b);
                    queue_item(tx ? MODE_TX_DATA : MODE_RX_DATA, $urandom, $urandom, $urandom,
                               b, 1'b0);
                end
                if (!tx && n == len)
                begin
                    flip = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : 8'h00;
                    queue_item(MODE_RX_DATA, $urandom, $urandom, $urandom, ~sum ^ flip, 1'b0);
                end
            end
            else if (pick < 82)
                queue_item($urandom_range(0, 1) ? MODE_TX_DATA : MODE_RX_DATA, $urandom,
                           $urandom, $urandom, $urandom, 1'b0);
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1))
                    id = $urandom_range(64, 255);
                else
                begin
                    id = $urandom_range(0, 63);
                    while (gen_ok[id])
                        id = $urandom_range(0, 63);
                end
                queue_item($urandom_range(0, 1) ? MODE_TX_START : MODE_RX_START, id,
                           $urandom, $urandom, $urandom, 1'b0);
            end
            else if (pick < 95)
                queue_item(MODE_REGISTER, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else if (pick < 97)
                queue_item(MODE_BEGIN, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else
                queue_item($urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7, $urandom,
                           $urandom, $urandom, $urandom, 1'b0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (lin_requests.size() != 0 || item_in.valid)
            @(posedge clk);
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && bus_results_due.size() == 0)
            $display("tb_lin_master_frame_engine: clean");
        else
            $display("tb_lin_master_frame_engine: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_lin_master_frame_engine: errors");
        $finish;
    end

endmodule
